// ===== rtl/core/jpeg_block_entropy_coder_defines.svh =====
// assertion macros used by the coder top level
`ifndef JPEG_BLOCK_ENTROPY_CODER_DEFINES_SVH
`define JPEG_BLOCK_ENTROPY_CODER_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property checked on every clock outside reset
`define JBEC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jbec assertion failed");
// antecedent in this cycle, consequent in the next one
`define JBEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jbec assertion failed");
`else
`define JBEC_ASSERT(lbl, prop)
`define JBEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/jbec_pkg.sv =====
`timescale 1ns / 1ps

package jbec_pkg;

    // register indexes of the configuration channel
    localparam logic CFG_MAX_LEVEL = 1'b0;
    localparam logic CFG_MIN_LEVEL = 1'b1;

    localparam logic [1:0] COMP_LUMA = 2'd0;
    localparam logic [1:0] COMP_CB   = 2'd1;
    localparam logic [1:0] COMP_CR   = 2'd2;
    localparam logic [1:0] COMP_BAD  = 2'd3;

    localparam logic [5:0] LAST_POSITION = 6'd63;
    localparam logic [7:0] ZRL_SYMBOL    = 8'hf0;
    localparam logic [7:0] EOB_SYMBOL    = 8'h00;
    localparam logic signed [10:0] DC_RESET = 11'sd128;

    // rom entry: length in [20:16], code in [15:0]
    typedef logic [20:0] code_entry_t;
    typedef code_entry_t ac_rom_t [256];
    typedef code_entry_t dc_rom_t [16];
    typedef logic [7:0] count_list_t [16];
    typedef logic [7:0] sym_list_t [162];

    // what the encoder reports for the item in the input register
    typedef struct packed {
        logic        has_final;
        logic [1:0]  zrl_need;
        logic [25:0] final_bits;
        logic [4:0]  final_count;
        logic [25:0] zrl_bits;
        logic [4:0]  zrl_count;
        logic        is_dc;
        logic [1:0]  comp;
        logic [10:0] dc_value;
        logic [5:0]  run_next;
    } enc_result_t;

    localparam count_list_t DC_LUMA_COUNTS =
        '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
    localparam count_list_t DC_CHROMA_COUNTS =
        '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
    localparam count_list_t AC_LUMA_COUNTS =
        '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
    localparam count_list_t AC_CHROMA_COUNTS =
        '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};

    localparam sym_list_t AC_LUMA_SYMS = '{
        8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
        8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,
        8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,
        8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
        8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,
        8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
        8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
        8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,
        8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
        8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,
        8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
        8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,8'hf4,
        8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
    };

    localparam sym_list_t AC_CHROMA_SYMS = '{
        8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,
        8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,
        8'ha1,8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,
        8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,
        8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,
        8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
        8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
        8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,
        8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
        8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
        8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,8'hf4,
        8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
    };

    // canonical huffman codes, elaboration time only
    function automatic ac_rom_t build_ac_rom(input count_list_t counts, input sym_list_t syms);
        ac_rom_t     rom;
        logic [16:0] code;
        int          k;
        rom  = '{default: '0};
        code = '0;
        k    = 0;
        for (int len = 1; len <= 16; len++)
        begin
            for (int i = 0; i < int'(counts[len-1]); i++)
            begin
                if (k < 162)
                begin
                    rom[syms[k]] = {5'(len), code[15:0]};
                end
                k++;
                code = code + 17'd1;
            end
            code = code << 1;
        end
        return rom;
    endfunction

    function automatic dc_rom_t build_dc_rom(input count_list_t counts);
        dc_rom_t     rom;
        logic [16:0] code;
        int          k;
        rom  = '{default: '0};
        code = '0;
        k    = 0;
        for (int len = 1; len <= 16; len++)
        begin
            for (int i = 0; i < int'(counts[len-1]); i++)
            begin
                if (k < 12)
                begin
                    rom[k] = {5'(len), code[15:0]};
                end
                k++;
                code = code + 17'd1;
            end
            code = code << 1;
        end
        return rom;
    endfunction

    localparam ac_rom_t AC_LUMA_ROM   = build_ac_rom(AC_LUMA_COUNTS, AC_LUMA_SYMS);
    localparam ac_rom_t AC_CHROMA_ROM = build_ac_rom(AC_CHROMA_COUNTS, AC_CHROMA_SYMS);
    localparam dc_rom_t DC_LUMA_ROM   = build_dc_rom(DC_LUMA_COUNTS);
    localparam dc_rom_t DC_CHROMA_ROM = build_dc_rom(DC_CHROMA_COUNTS);

endpackage

// ===== rtl/core/jpeg_block_entropy_coder.sv =====
`timescale 1ns / 1ps
// path: a coefficient waits in the input register, its codes in the result register
// throughput: one coefficient per cycle unless the output stalls; a nonzero term
//   after long zero runs holds the input as the single result register emits ZRL codes
// reset: clears the pipeline, zero run and scan position, sets all dc predictors
//   to 128 and the clip limits to 1023 and -1023

`include "jpeg_block_entropy_coder_defines.svh"

module jpeg_block_entropy_coder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // coef[11:0], zero fill
    input  logic [2:0]  s_tuser,   // frame_start[0], component[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // bits[25:0], bit_count[30:26], zero fill
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    logic               in_valid_reg;
    logic               frame_start_reg;
    logic [1:0]         component_reg;
    logic signed [11:0] coef_reg;
    logic [9:0]         max_level_reg;
    logic [10:0]        min_level_reg;
    logic [2:0][10:0]   pred_reg;
    logic [2:0][10:0]   pred_next;
    logic [5:0]         run_reg;
    logic [5:0]         scan_reg;
    logic [1:0]         zrl_cnt_reg;
    logic               out_valid_reg;
    logic [25:0]        out_bits_reg;
    logic [4:0]         out_count_reg;
    logic               out_last_reg;

    jbec_pkg::enc_result_t enc;
    logic out_free;
    logic emit_zrl;
    logic step;
    logic retire;
    logic out_load;
    logic in_load;

    jbec_encode u_encode
    (
        .frame_start   (frame_start_reg),
        .component     (component_reg),
        .coef          (coef_reg),
        .max_level     (max_level_reg),
        .min_level     (min_level_reg),
        .dc_pred       (pred_reg),
        .zero_run      (run_reg),
        .scan_position (scan_reg),
        .result        (enc)
    );

    // sequencing of zrl codes and the final code
    assign out_free = !out_valid_reg || m_tready;
    assign emit_zrl = in_valid_reg && (zrl_cnt_reg < enc.zrl_need);
    assign step     = in_valid_reg && (out_free || (!emit_zrl && !enc.has_final));
    assign retire   = step && !emit_zrl;
    assign out_load = step && (emit_zrl || enc.has_final);
    assign s_tready = !in_valid_reg || retire;
    assign in_load  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            frame_start_reg <= s_tuser[0];
            component_reg   <= s_tuser[2:1];
            coef_reg        <= $signed(s_tdata[11:0]);
        end
    end

    // configuration transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= 10'd1023;
            min_level_reg <= 11'h401;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                jbec_pkg::CFG_MAX_LEVEL: max_level_reg <= cfg_data[9:0];
                jbec_pkg::CFG_MIN_LEVEL: min_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // predictor update on retire
    always_comb
    begin
        pred_next = pred_reg;
        if (frame_start_reg)
            pred_next = {3{jbec_pkg::DC_RESET}};
        if (enc.is_dc)
            pred_next[enc.comp] = enc.dc_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg    <= {3{jbec_pkg::DC_RESET}};
            run_reg     <= 6'd0;
            scan_reg    <= 6'd0;
            zrl_cnt_reg <= 2'd0;
        end
        else if (retire)
        begin
            pred_reg    <= pred_next;
            run_reg     <= enc.run_next;
            scan_reg    <= scan_reg + 6'd1;
            zrl_cnt_reg <= 2'd0;
        end
        else if (step)
        begin
            zrl_cnt_reg <= zrl_cnt_reg + 2'd1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bits_reg  <= emit_zrl ? enc.zrl_bits  : enc.final_bits;
            out_count_reg <= emit_zrl ? enc.zrl_count : enc.final_count;
            out_last_reg  <= !emit_zrl;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_bits_reg};
    assign m_tlast  = out_last_reg;

    `JBEC_ASSERT(a_zrl_bound, !in_valid_reg || (zrl_cnt_reg <= enc.zrl_need))
    `JBEC_ASSERT_NEXT(a_zrl_not_last, step && emit_zrl, m_tvalid && !m_tlast)
    `JBEC_ASSERT_NEXT(a_scan_hold, !retire, $stable(scan_reg))
    `JBEC_ASSERT_NEXT(a_run_clear, retire && (scan_reg == jbec_pkg::LAST_POSITION),
        run_reg == 6'd0)

endmodule

// ===== rtl/core/jbec_encode.sv =====
`timescale 1ns / 1ps

module jbec_encode
(
    input  logic                    frame_start,
    input  logic [1:0]              component,
    input  logic signed [11:0]      coef,
    input  logic [9:0]              max_level,
    input  logic [10:0]             min_level,
    input  logic [2:0][10:0]        dc_pred,
    input  logic [5:0]              zero_run,
    input  logic [5:0]              scan_position,
    output jbec_pkg::enc_result_t   result
);

    logic [1:0]          comp_eff;
    logic                chroma;
    logic signed [11:0]  max_ext;
    logic signed [11:0]  min_ext;
    logic signed [11:0]  clip;
    logic signed [10:0]  pred_sel;
    logic signed [11:0]  diff;
    logic signed [11:0]  ac_val;
    logic signed [11:0]  value;
    logic [11:0]         mag;
    logic [3:0]          cat;
    logic                is_dc;
    logic                is_zero;
    logic                is_last;
    logic [3:0]          nbits;
    jbec_pkg::code_entry_t dc_entry;
    jbec_pkg::code_entry_t ac_entry;
    jbec_pkg::code_entry_t eob_entry;
    jbec_pkg::code_entry_t zrl_entry;
    jbec_pkg::code_entry_t sel_entry;
    logic [12:0]         val_adj;
    logic [12:0]         mask;
    logic [26:0]         shifted;

    // component three uses the Cr tables and predictor
    assign comp_eff = (component == jbec_pkg::COMP_BAD) ? jbec_pkg::COMP_CR : component;
    assign chroma   = (comp_eff != jbec_pkg::COMP_LUMA);

    // clip, upper limit first
    assign max_ext = $signed({2'b00, max_level});
    assign min_ext = $signed({min_level[10], min_level});
    always_comb
    begin
        if (coef > max_ext)
            clip = max_ext;
        else if (coef < min_ext)
            clip = min_ext;
        else
            clip = coef;
    end

    assign is_dc   = (scan_position == 6'd0);
    assign is_zero = (clip == 12'sd0);
    assign is_last = (scan_position == jbec_pkg::LAST_POSITION);

    // dc difference and ac saturation
    assign pred_sel = frame_start ? jbec_pkg::DC_RESET : $signed(dc_pred[comp_eff]);
    assign diff     = clip - $signed({pred_sel[10], pred_sel});
    assign ac_val   = (clip < -12'sd1023) ? -12'sd1023 : clip;
    assign value    = is_dc ? diff : ac_val;
    assign mag      = value[11] ? 12'(-value) : 12'(value);

    // magnitude category
    always_comb
    begin
        cat = 4'd0;
        for (int i = 0; i < 11; i++)
        begin
            if (mag[i])
                cat = 4'(i + 1);
        end
    end

    // table lookups
    assign dc_entry  = chroma ? jbec_pkg::DC_CHROMA_ROM[cat] : jbec_pkg::DC_LUMA_ROM[cat];
    assign ac_entry  = chroma ? jbec_pkg::AC_CHROMA_ROM[{zero_run[3:0], cat}]
                              : jbec_pkg::AC_LUMA_ROM[{zero_run[3:0], cat}];
    assign eob_entry = chroma ? jbec_pkg::AC_CHROMA_ROM[jbec_pkg::EOB_SYMBOL]
                              : jbec_pkg::AC_LUMA_ROM[jbec_pkg::EOB_SYMBOL];
    assign zrl_entry = chroma ? jbec_pkg::AC_CHROMA_ROM[jbec_pkg::ZRL_SYMBOL]
                              : jbec_pkg::AC_LUMA_ROM[jbec_pkg::ZRL_SYMBOL];

    always_comb
    begin
        priority if (is_dc)
        begin
            sel_entry = dc_entry;
            nbits     = cat;
        end
        else if (is_zero)
        begin
            sel_entry = eob_entry;
            nbits     = 4'd0;
        end
        else
        begin
            sel_entry = ac_entry;
            nbits     = cat;
        end
    end

    // code followed by magnitude bits, negative values one less
    assign val_adj = value[11] ? 13'($signed(value) - 12'sd1) : {1'b0, value};
    assign mask    = (13'd1 << nbits) - 13'd1;
    assign shifted = ({11'd0, sel_entry[15:0]} << nbits) | {14'd0, val_adj & mask};

    always_comb
    begin
        result.has_final   = is_dc || !is_zero || is_last;
        result.zrl_need    = (!is_dc && !is_zero) ? zero_run[5:4] : 2'd0;
        result.final_bits  = shifted[25:0];
        result.final_count = 5'(sel_entry[20:16] + {1'b0, nbits});
        result.zrl_bits    = {10'd0, zrl_entry[15:0]};
        result.zrl_count   = zrl_entry[20:16];
        result.is_dc       = is_dc;
        result.comp        = comp_eff;
        result.dc_value    = clip[10:0];
        if (is_dc || is_last || !is_zero)
            result.run_next = 6'd0;
        else
            result.run_next = zero_run + 6'd1;
    end

endmodule

// ===== dv/jpeg_block_entropy_coder_tb.sv =====
`timescale 1ns / 1ps

module jpeg_block_entropy_coder_tb;

    typedef struct {
        logic [25:0] bits;
        logic [4:0]  count;
        logic        last;
    } code_word_t;

    typedef struct {
        logic              fs;
        logic [1:0]        comp;
        logic signed [11:0] coef;
        logic              typed;
        logic [25:0]       t_bits;
        logic [4:0]        t_count;
    } coef_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [10:0] cfg_data;

    // huffman tables and coder state kept by the testbench
    logic [20:0] dc_codes [24];
    logic [20:0] ac_codes [512];
    int          dc_pred [3];
    int          zero_run;
    int          scan_pos;
    int          clip_hi;
    int          clip_lo;

    code_word_t  code_q [$];
    int          errors;
    int          n_items;
    int          n_codes;
    int          n_zrl;
    int          n_eob;
    logic        no_idle;
    int          hold_cnt;
    logic        hold_req;

    coef_row_t   rows [25];

    jpeg_block_entropy_coder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // canonical code assignment from per-length counts
    task automatic fill_table(input int base, input jbec_pkg::count_list_t counts,
                              input jbec_pkg::sym_list_t syms, input bit is_dc);
        int code;
        int k;
        int sym;
        code = 0;
        k    = 0;
        for (int len = 1; len <= 16; len++)
        begin
            for (int i = 0; i < counts[len-1]; i++)
            begin
                sym = is_dc ? k : syms[k];
                if (is_dc && k < 12)
                    dc_codes[base + sym] = {5'(len), 16'(code)};
                else if (!is_dc && k < 162)
                    ac_codes[base + sym] = {5'(len), 16'(code)};
                k++;
                code++;
            end
            code = code << 1;
        end
    endtask

    function automatic int mag_size(input int mag);
        int n;
        n = 0;
        while (mag != 0)
        begin
            mag = mag >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic code_word_t make_word(input logic [20:0] entry, input int nbits,
                                             input int value);
        code_word_t w;
        logic [31:0] mant;
        logic [47:0] full;
        mant = 0;
        if (nbits != 0)
            mant = 32'(value < 0 ? value - 1 : value) & ((32'd1 << nbits) - 1);
        full    = (48'(entry[15:0]) << nbits) | 48'(mant);
        w.bits  = full[25:0];
        w.count = 5'(entry[20:16] + nbits);
        w.last  = 1'b0;
        return w;
    endfunction

    // predicts the code words produced by one coefficient
    task automatic encode_coef(input logic fs, input logic [1:0] comp_in,
                               input logic signed [11:0] coef);
        int c;
        int comp;
        int chroma;
        int diff;
        int cat;
        int n;
        n      = 0;
        comp   = (comp_in > 2) ? 2 : comp_in;
        chroma = (comp != 0);
        c      = coef;
        if (fs)
            dc_pred = '{128, 128, 128};
        if (c > clip_hi)
            c = clip_hi;
        else if (c < clip_lo)
            c = clip_lo;
        if (scan_pos == 0)
        begin
            diff  = c - dc_pred[comp];
            cat   = mag_size(diff < 0 ? -diff : diff);
            dc_pred[comp] = c;
            zero_run = 0;
            code_q.push_back(make_word(dc_codes[(chroma * 12 + (cat & 15)) % 24], cat, diff));
            n++;
        end
        else if (c == 0)
        begin
            zero_run = (zero_run + 1) & 63;
            if (scan_pos == 63)
            begin
                code_q.push_back(make_word(ac_codes[chroma * 256], 0, 0));
                n++;
                n_eob++;
            end
        end
        else
        begin
            if (c < -1023)
                c = -1023;
            cat = mag_size(c < 0 ? -c : c);
            while (zero_run >= 16)
            begin
                code_q.push_back(make_word(ac_codes[chroma * 256 + jbec_pkg::ZRL_SYMBOL],
                                           0, 0));
                n++;
                n_zrl++;
                zero_run -= 16;
            end
            code_q.push_back(make_word(ac_codes[chroma * 256 + (((zero_run << 4) | cat) % 256)],
                                       cat, c));
            n++;
            zero_run = 0;
        end
        if (scan_pos == 63)
            zero_run = 0;
        scan_pos = (scan_pos + 1) & 63;
        if (n > 0)
            code_q[$].last = 1'b1;
    endtask

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // one coefficient transaction with random idle gaps
    task automatic send_coef(input logic fs, input logic [1:0] comp,
                             input logic signed [11:0] coef);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, coef};
        s_tuser  <= {comp, fs};
        do
            @(posedge clk);
        while (!s_tready);
        encode_coef(fs, comp, coef);
        n_items++;
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] value);
        @(negedge clk);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == jbec_pkg::CFG_MAX_LEVEL)
            clip_hi = value[9:0];
        else
            clip_lo = $signed(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let the pipeline drain before touching registers
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (code_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic signed [11:0] pick_coef(input int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return 12'sd0;
        r = $urandom_range(99);
        if (r < 50)
            return 12'($urandom_range(1, 15) * ($urandom_range(1) ? 1 : -1));
        if (r < 90)
            return 12'($urandom);
        case ($urandom_range(5))
            0: return -12'sd2048;
            1: return 12'sd2047;
            2: return -12'sd1024;
            3: return 12'sd1023;
            4: return 12'sd1024;
            default: return -12'sd1;
        endcase
    endfunction

    // random coefficients, sparse blocks now and then for long zero runs
    task automatic random_coefs(input int count);
        int          zero_pct;
        logic [1:0]  comp;
        logic        fs;
        for (int i = 0; i < count; i++)
        begin
            if (scan_pos == 0 || i == 0)
            begin
                zero_pct = ($urandom_range(3) == 0) ? 97 : 55;
                comp     = 2'($urandom_range(3));
            end
            if ($urandom_range(19) == 0)
                comp = 2'($urandom_range(3));
            fs = ($urandom_range(19) == 0);
            send_coef(fs, comp, pick_coef(zero_pct));
        end
    endtask

    // receiver side with random stalls and a long hold on request
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt == 0)
            hold_cnt <= 300;
        if (hold_cnt > 0)
        begin
            m_tready <= 1'b0;
            if (hold_cnt == 1)
                hold_req <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 33);
    end

    // compare each code word transaction with the oldest prediction
    always @(posedge clk)
    begin
        code_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_codes++;
            if (code_q.size() == 0)
                report($sformatf("unexpected code word %h", m_tdata));
            else
            begin
                w = code_q.pop_front();
                if (m_tdata[25:0] !== w.bits)
                    report($sformatf("bits %h, want %h", m_tdata[25:0], w.bits));
                if (m_tdata[30:26] !== w.count)
                    report($sformatf("bit_count %0d, want %0d", m_tdata[30:26], w.count));
                if (m_tdata[31] !== 1'b0)
                    report("tdata fill bit set");
                if (m_tlast !== w.last)
                    report($sformatf("tlast %b, want %b", m_tlast, w.last));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d code words pending", code_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = jbec_pkg::CFG_MAX_LEVEL;
        cfg_data  = '0;
        no_idle   = 1'b0;
        hold_cnt  = 0;
        hold_req  = 1'b0;
        errors    = 0;
        n_items   = 0;
        n_codes   = 0;
        n_zrl     = 0;
        n_eob     = 0;
        dc_codes  = '{default: '0};
        ac_codes  = '{default: '0};
        fill_table(0, jbec_pkg::DC_LUMA_COUNTS, jbec_pkg::AC_LUMA_SYMS, 1'b1);
        fill_table(12, jbec_pkg::DC_CHROMA_COUNTS, jbec_pkg::AC_LUMA_SYMS, 1'b1);
        fill_table(0, jbec_pkg::AC_LUMA_COUNTS, jbec_pkg::AC_LUMA_SYMS, 1'b0);
        fill_table(256, jbec_pkg::AC_CHROMA_COUNTS, jbec_pkg::AC_CHROMA_SYMS, 1'b0);
        dc_pred  = '{128, 128, 128};
        zero_run = 0;
        scan_pos = 0;
        clip_hi  = 1023;
        clip_lo  = -1023;

        // directed block start: dc equal to predictor, clipping, zrl, odd component
        rows[0] = '{1'b0, jbec_pkg::COMP_LUMA, 12'sd128, 1'b1, 26'd0, 5'd2};
        rows[1] = '{1'b0, jbec_pkg::COMP_LUMA, 12'sd2047, 1'b0, '0, '0};
        rows[2] = '{1'b0, jbec_pkg::COMP_LUMA, -12'sd2048, 1'b0, '0, '0};
        for (int i = 3; i < 21; i++)
            rows[i] = '{1'b0, jbec_pkg::COMP_LUMA, 12'sd0, 1'b0, '0, '0};
        rows[21] = '{1'b0, jbec_pkg::COMP_LUMA, 12'sd1, 1'b0, '0, '0};
        rows[22] = '{1'b0, jbec_pkg::COMP_BAD, -12'sd1, 1'b0, '0, '0};
        rows[23] = '{1'b0, jbec_pkg::COMP_CB, 12'sd5, 1'b0, '0, '0};
        rows[24] = '{1'b1, jbec_pkg::COMP_CR, 12'sd0, 1'b0, '0, '0};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits restated once, then directed rows
        write_reg(jbec_pkg::CFG_MAX_LEVEL, 11'd1023);
        write_reg(jbec_pkg::CFG_MIN_LEVEL, -11'sd1023);
        foreach (rows[i])
        begin
            send_coef(rows[i].fs, rows[i].comp, rows[i].coef);
            if (rows[i].typed)
            begin
                code_q[$].bits  = rows[i].t_bits;
                code_q[$].count = rows[i].t_count;
            end
        end
        random_coefs(100);

        // everything clipped to zero
        drain();
        write_reg(jbec_pkg::CFG_MAX_LEVEL, 11'd0);
        write_reg(jbec_pkg::CFG_MIN_LEVEL, 11'd0);
        random_coefs(40);

        // most negative lower limit, small upper limit
        drain();
        write_reg(jbec_pkg::CFG_MAX_LEVEL, 11'd5);
        write_reg(jbec_pkg::CFG_MIN_LEVEL, -11'sd1024);
        random_coefs(70);

        // lower limit above upper limit
        drain();
        write_reg(jbec_pkg::CFG_MAX_LEVEL, 11'd10);
        write_reg(jbec_pkg::CFG_MIN_LEVEL, 11'sd100);
        random_coefs(30);

        // full range: a stretch with no idling, then a long output stall
        drain();
        write_reg(jbec_pkg::CFG_MAX_LEVEL, 11'd1023);
        write_reg(jbec_pkg::CFG_MIN_LEVEL, -11'sd1023);
        no_idle = 1'b1;
        random_coefs(60);
        no_idle  = 1'b0;
        hold_req = 1'b1;
        random_coefs(55);

        drain();
        repeat (20) @(posedge clk);
        $display("coefficients sent: %0d, code words checked: %0d", n_items, n_codes);
        $display("zrl codes: %0d, end-of-block codes: %0d, five clip settings", n_zrl, n_eob);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/jbec_pkg.sv
rtl/core/jbec_encode.sv
rtl/core/jpeg_block_entropy_coder.sv
dv/jpeg_block_entropy_coder_tb.sv
